[hw/rtl/rlm_pkg.sv]
// ----------------------------------------------------------------------------
// rlm_pkg: shared types and constants of the RMS level meter
// Payload structs, microcode word layout and fixed-point constants.
// ----------------------------------------------------------------------------
package rlm_pkg;

    // Longest frame before count and sum saturate.
    localparam int MAX_FRAMES = 1024;

    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int SUM_W  = CNT_W + 30;          // each square is at most 2^30
    localparam int MANT_W = 31;                  // Q30 mantissa in [2^30, 2^31)
    localparam int FRAC_W = 16;                  // log2 fraction bits
    localparam int EXP_W  = $clog2(SUM_W);
    localparam int LOG_W  = EXP_W + FRAC_W;
    localparam int DIFF_W = LOG_W + 2;
    localparam int LOOP_W = $clog2(FRAC_W);
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SEQ_W  = 4;                   // 16 microcode steps
    localparam int NRM_W  = 6;                   // normalize shift amount

    // 256 * 10 * log10(2) in Q16.
    localparam logic [MUL_W-1:0] DB_PER_LOG2_Q16 = 32'd50504453;
    localparam logic [15:0] FLOOR_Q8 = 16'hA000;   // -96 dB
    localparam logic [15:0] LOW_MAG  = 16'd30720;  // clamp at -120 dB
    localparam logic signed [DIFF_W-1:0] MANT_OFS = DIFF_W'(30 * 65536);

    localparam longint unsigned TEN_POW_12 = 64'd1000000000000;
    localparam longint unsigned FULL_MAX   = longint'(MAX_FRAMES) << 30;
    localparam int SILENT_MAX = int'(FULL_MAX / TEN_POW_12);

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } t_in;

    typedef struct packed {
        logic signed [15:0] level_db_q8;
        logic               overflow;
    } t_out;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_SAMPLE,
        MUL_MANT,
        MUL_SCALE
    } t_mul_sel;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ACC,
        OP_LOAD,
        OP_NORM,
        OP_MANT,
        OP_BIT,
        OP_LOGDONE,
        OP_EMIT
    } t_uop;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_ACCEPT,
        C_NOT_LAST,
        C_LOOP,
        C_PASS0,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        logic             in_rdy;
        t_mul_sel         mul_sel;
        t_uop             op;
        logic [NRM_W-1:0] nrm;
        t_cond            cond;
        logic [SEQ_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic accept;
        logic not_last;
        logic loop_more;
        logic pass0;
        logic out_busy;
    } t_seq_status;

    // floor(cnt * 2^30 / 10^12): compares against constant thresholds only.
    function automatic logic [SUM_W-1:0] f_silent_thresh(input logic [CNT_W-1:0] cnt);
        logic [SUM_W-1:0] thr;
        thr = '0;
        for (int k = 1; k <= SILENT_MAX; k++) begin
            if (64'({cnt, 30'b0}) >= longint'(k) * TEN_POW_12) begin
                thr = thr + SUM_W'(1);
            end
        end
        return thr;
    endfunction

endpackage

[hw/rtl/rlm_seq.sv]
// ----------------------------------------------------------------------------
// rlm_seq: microcode sequencer of the RMS level meter
// Step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module rlm_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rlm_pkg::t_seq_status i_status,
    output rlm_pkg::t_uword      o_uword
);
    import rlm_pkg::*;

    logic [SEQ_W-1:0] r_pc;
    logic [SEQ_W-1:0] n_pc;
    t_uword           uw;
    logic             take;

    function automatic t_uword mk(input logic rdy, input t_mul_sel ms, input t_uop op,
                                  input logic [NRM_W-1:0] nrm, input t_cond cond,
                                  input logic [SEQ_W-1:0] tgt);
        t_uword w;
        w.in_rdy  = rdy;
        w.mul_sel = ms;
        w.op      = op;
        w.nrm     = nrm;
        w.cond    = cond;
        w.target  = tgt;
        return w;
    endfunction

    // Control store.
    function automatic t_uword f_ucode(input logic [SEQ_W-1:0] pc);
        t_uword w;
        case (pc)
            // wait for a sample, square it on the way in
            4'd0:    w = mk(1'b1, MUL_SAMPLE, OP_NOP,     6'd0,  C_NO_ACCEPT, 4'd0);
            4'd1:    w = mk(1'b0, MUL_NONE,   OP_ACC,     6'd0,  C_NOT_LAST,  4'd0);
            4'd2:    w = mk(1'b0, MUL_NONE,   OP_LOAD,    6'd0,  C_NEXT,      4'd0);
            // log2 subroutine: binary normalize
            4'd3:    w = mk(1'b0, MUL_NONE,   OP_NORM,    6'd32, C_NEXT,      4'd0);
            4'd4:    w = mk(1'b0, MUL_NONE,   OP_NORM,    6'd16, C_NEXT,      4'd0);
            4'd5:    w = mk(1'b0, MUL_NONE,   OP_NORM,    6'd8,  C_NEXT,      4'd0);
            4'd6:    w = mk(1'b0, MUL_NONE,   OP_NORM,    6'd4,  C_NEXT,      4'd0);
            4'd7:    w = mk(1'b0, MUL_NONE,   OP_NORM,    6'd2,  C_NEXT,      4'd0);
            4'd8:    w = mk(1'b0, MUL_NONE,   OP_NORM,    6'd1,  C_NEXT,      4'd0);
            4'd9:    w = mk(1'b0, MUL_NONE,   OP_MANT,    6'd0,  C_NEXT,      4'd0);
            // fraction bits: square, then test and halve
            4'd10:   w = mk(1'b0, MUL_MANT,   OP_NOP,     6'd0,  C_NEXT,      4'd0);
            4'd11:   w = mk(1'b0, MUL_NONE,   OP_BIT,     6'd0,  C_LOOP,      4'd10);
            4'd12:   w = mk(1'b0, MUL_NONE,   OP_LOGDONE, 6'd0,  C_PASS0,     4'd3);
            4'd13:   w = mk(1'b0, MUL_SCALE,  OP_NOP,     6'd0,  C_NEXT,      4'd0);
            4'd14:   w = mk(1'b0, MUL_NONE,   OP_NOP,     6'd0,  C_OUT_BUSY,  4'd14);
            4'd15:   w = mk(1'b0, MUL_NONE,   OP_EMIT,    6'd0,  C_ALWAYS,    4'd0);
            default: w = mk(1'b0, MUL_NONE,   OP_NOP,     6'd0,  C_ALWAYS,    4'd0);
        endcase
        return w;
    endfunction

    assign uw = f_ucode(r_pc);

    always_comb begin
        case (uw.cond)
            C_ALWAYS:    take = 1'b1;
            C_NO_ACCEPT: take = !i_status.accept;
            C_NOT_LAST:  take = i_status.not_last;
            C_LOOP:      take = i_status.loop_more;
            C_PASS0:     take = i_status.pass0;
            C_OUT_BUSY:  take = i_status.out_busy;
            default:     take = 1'b0;
        endcase
        n_pc = take ? uw.target : r_pc + SEQ_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uword = uw;

endmodule

[hw/rtl/rms_level_meter_dbfs.sv]
// ----------------------------------------------------------------------------
// rms_level_meter_dbfs: frame level meter in dBFS
// Sum of squares per frame, reported as 10*log10(mean square) in Q8 dB.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one signed
//   16-bit sample per item plus a last flag closing the frame. The output
//   channel (o_out_valid / i_out_ready / o_out_data) gives one item per
//   frame: level in 1/256 dB (-30720..0, -96 dB floor for silence) and an
//   overflow flag set when the frame ran past MAX_FRAMES samples.
//   Sequence: a sample without last is accepted and squared, then
//   accumulated. A last sample runs the log program: two log2 passes
//   (6 normalize steps, mantissa load, 16 square/test pairs on the one
//   shared 32x32 multiplier, wrap-up), then scale and emit. After the emit
//   the result shows in the output register and the next sample is taken.
//   The result sits in an output register; the block goes on taking samples
//   of the next frame while it waits. If a second frame ends before the
//   first result is taken, the sequencer holds before emitting.
//   Reset (i_rst_n low, synchronous) clears sum, count, overflow flag,
//   output valid and the step counter; input ready stays low during reset.
// ----------------------------------------------------------------------------
module rms_level_meter_dbfs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rlm_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output rlm_pkg::t_out o_out_data
);
    import rlm_pkg::*;

    t_uword      uw;
    t_seq_status status;
    logic        in_accept;

    // frame state
    logic [SUM_W-1:0]  r_sum,  n_sum;
    logic [CNT_W-1:0]  r_cnt,  n_cnt;
    logic              r_ovf,  n_ovf;
    logic              r_last, n_last;
    // log datapath
    logic [PROD_W-1:0] r_prod, n_prod;
    logic [SUM_W-1:0]  r_x,    n_x;
    logic [EXP_W-1:0]  r_e,    n_e;
    logic [MANT_W-1:0] r_y,    n_y;
    logic [FRAC_W-1:0] r_frac, n_frac;
    logic [LOOP_W-1:0] r_loop, n_loop;
    logic              r_pass, n_pass;
    logic [LOG_W-1:0]  r_lsum, n_lsum;
    logic signed [DIFF_W-1:0] r_d, n_d;
    logic              r_silent, n_silent;
    // output register
    logic              r_out_valid, n_out_valid;
    t_out              r_out, n_out;

    logic [16:0]       smp_mag;
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [DIFF_W-1:0] d_mag;
    logic [LOG_W-1:0]  cur_log;
    logic              norm_zero;
    logic [32:0]       sq;
    logic              ge;
    logic [PROD_W-1:0] rnd;
    logic [15:0]       mag;

    rlm_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_uword  (uw)
    );

    assign o_in_ready = uw.in_rdy && i_rst_n;
    assign in_accept  = i_in_valid && o_in_ready;

    assign status.accept    = in_accept;
    assign status.not_last  = !r_last;
    assign status.loop_more = (r_loop != '0);
    assign status.pass0     = !r_pass;
    assign status.out_busy  = r_out_valid && !i_out_ready;

    // |sample|, -32768 gives 32768
    assign smp_mag = i_in_data.sample[15] ? (17'd0 - {1'b1, i_in_data.sample})
                                          : {1'b0, i_in_data.sample};
    assign d_mag   = DIFF_W'(0) - r_d;

    // single shared multiplier
    always_comb begin
        case (uw.mul_sel)
            MUL_SAMPLE: begin
                mul_a = MUL_W'(smp_mag);
                mul_b = MUL_W'(smp_mag);
            end
            MUL_MANT: begin
                mul_a = MUL_W'(r_y);
                mul_b = MUL_W'(r_y);
            end
            MUL_SCALE: begin
                mul_a = MUL_W'(d_mag);
                mul_b = DB_PER_LOG2_Q16;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign cur_log   = {r_e, r_frac};
    assign norm_zero = ((r_x & ~({SUM_W{1'b1}} >> uw.nrm)) == '0);
    assign sq        = r_prod[62:30];
    assign ge        = sq[32] | sq[31];

    // magnitude rounded to nearest, clamped
    assign rnd = r_prod + (PROD_W'(1) << 31);
    assign mag = (rnd[63:32] > 32'(LOW_MAG)) ? LOW_MAG : rnd[47:32];

    always_comb begin
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        n_ovf       = r_ovf;
        n_last      = r_last;
        n_prod      = r_prod;
        n_x         = r_x;
        n_e         = r_e;
        n_y         = r_y;
        n_frac      = r_frac;
        n_loop      = r_loop;
        n_pass      = r_pass;
        n_lsum      = r_lsum;
        n_d         = r_d;
        n_silent    = r_silent;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (uw.mul_sel != MUL_NONE) begin
            n_prod = mul_p;
        end
        if (in_accept) begin
            n_last = i_in_data.last;
        end

        case (uw.op)
            OP_ACC: begin
                if (r_cnt < CNT_W'(MAX_FRAMES)) begin
                    n_sum = r_sum + SUM_W'(r_prod[30:0]);
                    n_cnt = r_cnt + CNT_W'(1);
                end else begin
                    // sample dropped, frame saturated
                    n_ovf = 1'b1;
                end
            end
            OP_LOAD: begin
                n_x      = r_sum;
                n_e      = EXP_W'(SUM_W - 1);
                n_pass   = 1'b0;
                n_silent = (r_sum <= f_silent_thresh(r_cnt));
            end
            OP_NORM: begin
                if (norm_zero) begin
                    n_x = r_x << uw.nrm;
                    n_e = r_e - EXP_W'(uw.nrm);
                end
            end
            OP_MANT: begin
                n_y    = r_x[SUM_W-1 -: MANT_W];
                n_frac = '0;
                n_loop = '1;
            end
            OP_BIT: begin
                n_frac = {r_frac[FRAC_W-2:0], ge};
                n_y    = ge ? sq[31:1] : sq[30:0];
                n_loop = r_loop - LOOP_W'(1);
            end
            OP_LOGDONE: begin
                if (!r_pass) begin
                    // log2(sum) done, rerun on the count
                    n_lsum = cur_log;
                    n_x    = SUM_W'(r_cnt);
                    n_e    = EXP_W'(SUM_W - 1);
                    n_pass = 1'b1;
                end else begin
                    n_d = signed'(DIFF_W'(r_lsum)) - signed'(DIFF_W'(cur_log)) - MANT_OFS;
                end
            end
            OP_EMIT: begin
                n_out_valid = 1'b1;
                if (r_silent) begin
                    n_out.level_db_q8 = FLOOR_Q8;
                end else if (!r_d[DIFF_W-1]) begin
                    n_out.level_db_q8 = '0;
                end else begin
                    n_out.level_db_q8 = 16'd0 - mag;
                end
                n_out.overflow = r_ovf;
                n_sum = '0;
                n_cnt = '0;
                n_ovf = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_pass      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_sum       <= n_sum;
            r_cnt       <= n_cnt;
            r_ovf       <= n_ovf;
            r_pass      <= n_pass;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last   <= n_last;
        r_prod   <= n_prod;
        r_x      <= n_x;
        r_e      <= n_e;
        r_y      <= n_y;
        r_frac   <= n_frac;
        r_loop   <= n_loop;
        r_lsum   <= n_lsum;
        r_d      <= n_d;
        r_silent <= n_silent;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
